FILE: src/rfpc_pkg.sv
// ----------------------------------------------------------------------------
// Ring FIFO with peek cursor - shared definitions
// Sizes, command and status codes, and control types used by all modules but the slot RAM.
// ----------------------------------------------------------------------------
package rfpc_pkg;

   localparam int DEPTH      = 256;
   localparam int ITEM_WIDTH = 32;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CAP_W      = 9;
   localparam int DATA_W     = 32;
   localparam int CMP_W      = (ADDR_W + 1 > CAP_W) ?
                               ((ADDR_W + 1 > CNT_W) ? ADDR_W + 1 : CNT_W) :
                               ((CAP_W > CNT_W) ? CAP_W : CNT_W);
   localparam int DEPTH_CAP  = (DEPTH > (1 << CAP_W) - 1) ? (1 << CAP_W) - 1 : DEPTH;

   typedef enum logic [1:0] {
      CMD_PUSH       = 2'd0,
      CMD_POP        = 2'd1,
      CMD_PEEK       = 2'd2,
      CMD_PEEK_RESET = 2'd3
   } command_type;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [1:0] FILL_DATA  = 2'd0;
   localparam logic [1:0] FILL_EMPTY = 2'd1;
   localparam logic [1:0] FILL_FULL  = 2'd2;

   typedef enum logic {
      S_IDLE    = 1'b0,
      S_RESPOND = 1'b1
   } state_type;

   typedef struct packed {
      logic execute;
      logic respond;
   } ctrl_cmd_type;

endpackage

FILE: src/rfpc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module rfpc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  logic [WIDTH-1:0]                       write_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                       read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

FILE: src/rfpc_ctrl.sv
// ----------------------------------------------------------------------------
// Ring FIFO with peek cursor - controller
// Takes a command when idle and presents its result in the following cycle.
// ----------------------------------------------------------------------------
module rfpc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output rfpc_pkg::ctrl_cmd_type ctrl_cmd
);

   rfpc_pkg::state_type state_ff;
   rfpc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfpc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      ctrl_cmd.execute = 1'b0;
      ctrl_cmd.respond = 1'b0;
      busy             = 1'b0;
      unique case (state_ff)
         rfpc_pkg::S_IDLE: begin
            if (start) begin
               ctrl_cmd.execute = 1'b1;
               state_in         = rfpc_pkg::S_RESPOND;
            end
         end
         rfpc_pkg::S_RESPOND: begin
            busy             = 1'b1;
            ctrl_cmd.respond = 1'b1;
            state_in         = rfpc_pkg::S_IDLE;
         end
         default: begin
            state_in = rfpc_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: src/rfpc_datapath.sv
// ----------------------------------------------------------------------------
// Ring FIFO with peek cursor - datapath
// Slot pointers, item count, capacity register, slot store and result fields.
// ----------------------------------------------------------------------------
module rfpc_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  rfpc_pkg::ctrl_cmd_type           ctrl_cmd,
   input  logic [1:0]                       req_command,
   input  logic [rfpc_pkg::DATA_W-1:0]      req_write_data,
   input  logic                             csr_write_enable,
   input  logic [rfpc_pkg::CAP_W-1:0]       csr_write_data,
   output logic                             rsp_valid,
   output logic [rfpc_pkg::DATA_W-1:0]      rsp_read_data,
   output logic [1:0]                       rsp_status,
   output logic [1:0]                       rsp_fill_state,
   output logic [rfpc_pkg::CAP_W-1:0]       rsp_free_space
);

   localparam int AW = rfpc_pkg::ADDR_W;
   localparam int CW = rfpc_pkg::CMP_W;

   logic [AW-1:0]                  write_slot_ff, write_slot_in;
   logic [AW-1:0]                  read_slot_ff, read_slot_in;
   logic [AW-1:0]                  peek_slot_ff, peek_slot_in;
   logic [rfpc_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [rfpc_pkg::CAP_W-1:0]     cap_ff;
   logic [rfpc_pkg::DEPTH-1:0]     valid_ff, valid_in;
   logic [1:0]                     status_ff, status_in;
   logic [1:0]                     fill_ff, fill_in;
   logic [rfpc_pkg::CAP_W-1:0]     space_ff, space_in;
   logic                           data_sel_ff, data_sel_in;
   logic                           hit_ff;

   logic [rfpc_pkg::CAP_W-1:0]     cap_eff;
   logic [CW-1:0]                  cap_ext;
   logic [CW-1:0]                  count_ext;
   logic [CW-1:0]                  count_next_ext;
   logic [AW-1:0]                  read_addr;
   logic                           ram_write;
   logic [rfpc_pkg::DATA_W-1:0]    ram_rdata;
   rfpc_pkg::command_type          command;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos,
                                             input logic [CW-1:0] cap);
      logic [CW-1:0] next;
      next = CW'(pos) + CW'(1);
      if (next >= cap || next >= CW'(rfpc_pkg::DEPTH)) begin
         return '0;
      end
      return next[AW-1:0];
   endfunction

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = rfpc_pkg::CAP_W'(1);
      end else if (cap_ff > rfpc_pkg::CAP_W'(rfpc_pkg::DEPTH_CAP)) begin
         cap_eff = rfpc_pkg::CAP_W'(rfpc_pkg::DEPTH_CAP);
      end else begin
         cap_eff = cap_ff;
      end
   end

   assign cap_ext   = CW'(cap_eff);
   assign count_ext = CW'(count_ff);
   assign command   = rfpc_pkg::command_type'(req_command);

   always_comb begin
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      peek_slot_in  = peek_slot_ff;
      count_in      = count_ff;
      valid_in      = valid_ff;
      status_in     = rfpc_pkg::STATUS_DONE;
      data_sel_in   = 1'b0;
      ram_write     = 1'b0;
      read_addr     = peek_slot_ff;
      unique case (command)
         rfpc_pkg::CMD_PUSH: begin
            if (count_ext >= cap_ext) begin
               status_in = rfpc_pkg::STATUS_FULL;
            end else begin
               ram_write               = ctrl_cmd.execute;
               valid_in[write_slot_ff] = 1'b1;
               write_slot_in           = advance(write_slot_ff, cap_ext);
               count_in                = count_ff + rfpc_pkg::CNT_W'(1);
            end
         end
         rfpc_pkg::CMD_POP: begin
            read_addr = read_slot_ff;
            if (count_ff == '0) begin
               status_in = rfpc_pkg::STATUS_EMPTY;
            end else begin
               data_sel_in            = 1'b1;
               valid_in[read_slot_ff] = 1'b0;
               read_slot_in           = advance(read_slot_ff, cap_ext);
               count_in               = count_ff - rfpc_pkg::CNT_W'(1);
            end
         end
         rfpc_pkg::CMD_PEEK: begin
            data_sel_in  = 1'b1;
            peek_slot_in = advance(peek_slot_ff, cap_ext);
         end
         rfpc_pkg::CMD_PEEK_RESET: begin
            peek_slot_in = read_slot_ff;
         end
         default: begin
            status_in = rfpc_pkg::STATUS_DONE;
         end
      endcase
   end

   assign count_next_ext = CW'(count_in);

   always_comb begin
      if (count_in == '0) begin
         fill_in = rfpc_pkg::FILL_EMPTY;
      end else if (count_next_ext >= cap_ext) begin
         fill_in = rfpc_pkg::FILL_FULL;
      end else begin
         fill_in = rfpc_pkg::FILL_DATA;
      end
      if (count_next_ext >= cap_ext) begin
         space_in = '0;
      end else begin
         space_in = rfpc_pkg::CAP_W'(cap_ext - count_next_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         peek_slot_ff  <= '0;
         count_ff      <= '0;
         valid_ff      <= '0;
         cap_ff        <= rfpc_pkg::CAP_W'(rfpc_pkg::DEPTH_CAP);
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         if (ctrl_cmd.execute) begin
            write_slot_ff <= write_slot_in;
            read_slot_ff  <= read_slot_in;
            peek_slot_ff  <= peek_slot_in;
            count_ff      <= count_in;
            valid_ff      <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.execute) begin
         status_ff   <= status_in;
         fill_ff     <= fill_in;
         space_ff    <= space_in;
         data_sel_ff <= data_sel_in;
         hit_ff      <= valid_ff[read_addr];
      end
   end

   rfpc_ram #(
      .WIDTH (rfpc_pkg::ITEM_WIDTH),
      .DEPTH (rfpc_pkg::DEPTH)
   ) u_slots (
      .clock        (clock),
      .write_enable (ram_write),
      .write_addr   (write_slot_ff),
      .write_data   (rfpc_pkg::ITEM_WIDTH'(req_write_data)),
      .read_addr    (read_addr),
      .read_data    (ram_rdata)
   );

   assign rsp_valid      = ctrl_cmd.respond;
   assign rsp_read_data  = (data_sel_ff && hit_ff) ? ram_rdata : '0;
   assign rsp_status     = status_ff;
   assign rsp_fill_state = fill_ff;
   assign rsp_free_space = space_ff;

endmodule

FILE: src/ring_fifo_with_peek_cursor.sv
// ----------------------------------------------------------------------------
// Ring FIFO with peek cursor - top level
// Circular FIFO of 256 32-bit slots with a separately moving peek cursor.
// ----------------------------------------------------------------------------
// A command (push, pop, peek, reset peek cursor) with its write data is
// transferred at a clock edge where start is high and busy is low. Exactly one
// result follows: rsp_valid is high for one cycle, in the cycle right after the
// transfer, carrying read data, status, fill state and free space after the
// command. The receiver cannot hold results off; each result is taken in the
// cycle it is shown.
// The result is shown while busy is high, so the block takes no new command
// until the result of the last one has been shown. The read data in a result
// comes from the registered read of the slot RAM.
// The capacity register is written through csr_write_enable and
// csr_write_data at any edge; it is meant to change only while the FIFO is
// empty and idle. Synchronous reset empties the FIFO, returns all pointers to
// slot zero, sets the capacity to 256 and makes every slot read as zero
// through per-slot valid flags, so commands are taken in the first cycle
// after reset.
// ----------------------------------------------------------------------------
module ring_fifo_with_peek_cursor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_command,
   input  logic [rfpc_pkg::DATA_W-1:0] req_write_data,
   input  logic                        csr_write_enable,
   input  logic [rfpc_pkg::CAP_W-1:0]  csr_write_data,
   output logic                        rsp_valid,
   output logic [rfpc_pkg::DATA_W-1:0] rsp_read_data,
   output logic [1:0]                  rsp_status,
   output logic [1:0]                  rsp_fill_state,
   output logic [rfpc_pkg::CAP_W-1:0]  rsp_free_space
);

   rfpc_pkg::ctrl_cmd_type ctrl_cmd;

   rfpc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .ctrl_cmd (ctrl_cmd)
   );

   rfpc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl_cmd         (ctrl_cmd),
      .req_command      (req_command),
      .req_write_data   (req_write_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .rsp_fill_state   (rsp_fill_state),
      .rsp_free_space   (rsp_free_space)
   );

endmodule

FILE: src/rfpc_checker.sv
// ----------------------------------------------------------------------------
// Ring FIFO with peek cursor - port checker
// Temporal checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
module rfpc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [rfpc_pkg::DATA_W-1:0] rsp_read_data,
   input logic [1:0]                  rsp_status,
   input logic [1:0]                  rsp_fill_state,
   input logic [rfpc_pkg::CAP_W-1:0]  rsp_free_space
);

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid)
      else $error("Command transfer not followed by a result.");

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("Result shown while a new command could be taken.");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("More than one result for a command.");

   a_full_refusal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rfpc_pkg::STATUS_FULL |->
         rsp_fill_state == rfpc_pkg::FILL_FULL && rsp_free_space == '0)
      else $error("Refused push reports free space.");

   a_refusal_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rfpc_pkg::STATUS_DONE |-> rsp_read_data == '0)
      else $error("Refused command returned data.");

endmodule

bind ring_fifo_with_peek_cursor rfpc_checker u_rfpc_checker (.*);
